[design/speck128_cbc_engine_unit_macros.svh]
// Assertion macros for the speck128 CBC engine controller.
// No dependencies.
`ifndef SPECK128_CBC_ENGINE_UNIT_MACROS_SVH
`define SPECK128_CBC_ENGINE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SPK_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication.
`define SPK_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

[design/spk_pkg.sv]
// Package for the speck128 CBC engine: shared types and constants.
// No dependencies.
`default_nettype none
package spk_pkg;
	localparam int unsigned WordW  = 64;
	localparam int unsigned RkAw   = 6;
	localparam int unsigned CntW   = 5;
	localparam logic [WordW-1:0] PadWord = 64'h1010101010101010;

	localparam logic [2:0] RegKey0  = 3'd0;
	localparam logic [2:0] RegKey1  = 3'd1;
	localparam logic [2:0] RegKey2  = 3'd2;
	localparam logic [2:0] RegKey3  = 3'd3;
	localparam logic [2:0] RegKsize = 3'd4;
	localparam logic [2:0] RegMode  = 3'd5;
	localparam logic [2:0] RegIvX   = 3'd6;
	localparam logic [2:0] RegIvY   = 3'd7;

	// controller -> datapath
	typedef struct packed {
		logic ks_start;   // load key words, begin expansion
		logic ks_step;    // one key schedule step
		logic load_in;    // capture input block, xor chain for encrypt
		logic load_pad;   // capture pad block for encrypt
		logic rnd_step;   // one cipher round
		logic finish;     // finish block, update chain, fill output
		logic pad_last;   // output last flag for pad result
	} spk_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       ks_done;
		logic       rnd_done;
		logic       need_pad;
	} spk_sts_t;
endpackage
`default_nettype wire

[design/speck128_cbc_engine_unit.sv]
// Speck128 CBC engine top level: config registers, controller and datapath.
// Depends on spk_pkg, spk_ctrl, spk_datapath.
//
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata {last,first,in_bytes,y,x}
// m_axis    out  m_axis_tvalid/tready  tdata {err,last,out_bytes,y,x}
// cfg       in   cfg_we                cfg_index, cfg_data
//
// A request is taken in idle; 32..34 rounds follow, then the run state sees the
// count done and the finish state writes the result; no new request is taken
// before the engine is back in idle. An encrypt of a full last block runs a
// second pass for the pad block. A key or key_size write starts, in the next
// cycle, a key expansion of 31..33 steps; no request is taken until it is done.
// Reset clears state, chain and the configuration registers. A stalled output
// holds the engine before the next result is written.
`default_nettype none
module speck128_cbc_engine_unit #(
	parameter int unsigned MAX_ROUNDS = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// x[63:0], y[127:64], in_bytes[132:128], first_block[133], last_block[134]
	input  wire logic [135:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// x[63:0], y[127:64], out_bytes[132:128], out_last[133], pad_error[134]
	output logic [135:0]       m_axis_tdata,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [63:0]   cfg_data
);
	logic [63:0] key0_q, key1_q, key2_q, key3_q, ivx_q, ivy_q;
	logic [1:0] ksize_q;
	logic mode_q;
	logic key_wr;
	spk_pkg::spk_cmd_t cmd;
	spk_pkg::spk_sts_t sts;
	logic [63:0] rx, ry;
	logic [4:0] rb;
	logic rl, re;

	// configuration registers; key writes restart the key expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			ivx_q <= '0; ivy_q <= '0; ksize_q <= '0; mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				spk_pkg::RegKey0:  key0_q <= cfg_data;
				spk_pkg::RegKey1:  key1_q <= cfg_data;
				spk_pkg::RegKey2:  key2_q <= cfg_data;
				spk_pkg::RegKey3:  key3_q <= cfg_data;
				spk_pkg::RegKsize: ksize_q <= cfg_data[1:0];
				spk_pkg::RegMode:  mode_q <= cfg_data[0];
				spk_pkg::RegIvX:   ivx_q <= cfg_data;
				spk_pkg::RegIvY:   ivy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// expansion is launched the cycle after the write, from the new values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_wr <= 1'b0;
		else key_wr <= cfg_we && (cfg_index inside {spk_pkg::RegKey0, spk_pkg::RegKey1,
			spk_pkg::RegKey2, spk_pkg::RegKey3, spk_pkg::RegKsize});
	end

	spk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .key_wr(key_wr),
		.in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
		.out_tvalid(m_axis_tvalid), .out_tready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	spk_datapath #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.key0(key0_q), .key1(key1_q), .key2(key2_q), .key3(key3_q),
		.ksize(ksize_q), .decrypt(mode_q), .iv_x(ivx_q), .iv_y(ivy_q),
		.in_x(s_axis_tdata[63:0]), .in_y(s_axis_tdata[127:64]),
		.in_bytes(s_axis_tdata[132:128]), .in_first(s_axis_tdata[133]),
		.in_last(s_axis_tdata[134]),
		.cmd(cmd), .sts(sts),
		.res_x(rx), .res_y(ry), .res_bytes(rb), .res_last(rl), .res_err(re)
	);

	assign m_axis_tdata = {1'b0, re, rl, rb, ry, rx};
endmodule
`default_nettype wire

[design/spk_datapath.sv]
// Speck128 datapath: key schedule, round unit, round key memory, CBC chain.
// Depends on spk_pkg.
`default_nettype none
module spk_datapath #(
	parameter int unsigned MAX_ROUNDS = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [63:0]          key0,
	input  wire logic [63:0]          key1,
	input  wire logic [63:0]          key2,
	input  wire logic [63:0]          key3,
	input  wire logic [1:0]           ksize,
	input  wire logic                 decrypt,
	input  wire logic [63:0]          iv_x,
	input  wire logic [63:0]          iv_y,
	input  wire logic [63:0]          in_x,
	input  wire logic [63:0]          in_y,
	input  wire logic [4:0]           in_bytes,
	input  wire logic                 in_first,
	input  wire logic                 in_last,
	input  wire spk_pkg::spk_cmd_t    cmd,
	output spk_pkg::spk_sts_t         sts,
	output logic [63:0]               res_x,
	output logic [63:0]               res_y,
	output logic [4:0]                res_bytes,
	output logic                      res_last,
	output logic                      res_err
);
	localparam int unsigned Aw = $clog2(MAX_ROUNDS);

	logic [63:0] rk_mem [MAX_ROUNDS];
	logic [63:0] ks_k_q, l0_q, l1_q, l2_q;
	logic [Aw-1:0] ks_i_q;
	logic [1:0] code;
	logic [Aw-1:0] last_idx;
	logic [63:0] nl, nk;

	logic [63:0] x_q, y_q, cx_q, cy_q, chx_q, chy_q, rk_s1;
	logic [Aw-1:0] r_q;
	logic last_q, dec_q;
	logic [4:0] nb_q;
	logic [Aw-1:0] rd_addr;
	logic [63:0] ex, ey, dy, dx, xy;
	logic [63:0] px, py;
	logic [63:0] fx, fy;
	logic [7:0] pb;
	logic bad;

	assign code = (ksize[1]) ? 2'd2 : ksize;
	assign last_idx = Aw'(MAX_ROUNDS - 3) + Aw'(code);

	// key schedule step: l word rotates through a 1..3 deep queue
	assign nl = (ks_k_q + {l0_q[7:0], l0_q[63:8]}) ^ 64'(ks_i_q);
	assign nk = {ks_k_q[60:0], ks_k_q[63:61]} ^ nl;
	assign sts.ks_done = (ks_i_q == last_idx);

	always_ff @(posedge clk) begin
		if (cmd.ks_start) begin
			ks_k_q <= key0;
			l0_q   <= key1;
			l1_q   <= key2;
			l2_q   <= key3;
			ks_i_q <= '0;
			rk_mem[0] <= key0;
		end else if (cmd.ks_step) begin
			ks_k_q <= nk;
			rk_mem[ks_i_q + Aw'(1)] <= nk;
			ks_i_q <= ks_i_q + Aw'(1);
			case (code)
				2'd0: l0_q <= nl;
				2'd1: begin l0_q <= l1_q; l1_q <= nl; end
				default: begin l0_q <= l1_q; l1_q <= l2_q; l2_q <= nl; end
			endcase
		end
	end

	// round key read: registered, one key ahead of round use;
	// decrypt counter sits one above the key index in use
	assign rd_addr = dec_q ? (r_q - Aw'(2)) : (r_q + Aw'(1));
	always_ff @(posedge clk) begin
		if (cmd.load_in || cmd.load_pad)
			rk_s1 <= decrypt ? rk_mem[last_idx] : rk_mem[0];
		else if (cmd.rnd_step)
			rk_s1 <= rk_mem[rd_addr];
	end

	assign ex = ({x_q[7:0], x_q[63:8]} + y_q) ^ rk_s1;
	assign ey = {y_q[60:0], y_q[63:61]} ^ ex;
	assign xy = y_q ^ x_q;
	assign dy = {xy[2:0], xy[63:3]};
	assign dx = ((x_q ^ rk_s1) - dy);

	assign sts.rnd_done = dec_q ? (r_q == '0) : (r_q == last_idx + Aw'(1));
	assign sts.need_pad = last_q && !dec_q && (nb_q == 5'd16);

	// encrypt input with padding applied
	always_comb begin
		logic [4:0] nb;
		nb = (in_last && in_bytes < 5'd16) ? in_bytes : 5'd16;
		px = in_x;
		py = in_y;
		for (int i = 0; i < 8; i++) begin
			if (5'(i) >= nb) px[8*i +: 8] = 8'(5'd16 - nb);
			if (5'(i + 8) >= nb) py[8*i +: 8] = 8'(5'd16 - nb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chx_q <= '0;
			chy_q <= '0;
		end else if (cmd.load_in && in_first) begin
			chx_q <= iv_x;
			chy_q <= iv_y;
		end else if (cmd.finish) begin
			chx_q <= dec_q ? cx_q : x_q;
			chy_q <= dec_q ? cy_q : y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			logic [63:0] ch_x, ch_y;
			ch_x = in_first ? iv_x : chx_q;
			ch_y = in_first ? iv_y : chy_q;
			dec_q  <= decrypt;
			last_q <= in_last;
			nb_q   <= (in_last && in_bytes < 5'd16) ? in_bytes : 5'd16;
			cx_q   <= in_x;
			cy_q   <= in_y;
			x_q    <= decrypt ? in_x : (px ^ ch_x);
			y_q    <= decrypt ? in_y : (py ^ ch_y);
			r_q    <= decrypt ? (last_idx + Aw'(1)) : '0;
		end else if (cmd.load_pad) begin
			x_q    <= spk_pkg::PadWord ^ chx_q;
			y_q    <= spk_pkg::PadWord ^ chy_q;
			r_q    <= '0;
			nb_q   <= 5'd0;
		end else if (cmd.rnd_step) begin
			if (dec_q) begin
				x_q <= {dx[55:0], dx[63:56]};
				y_q <= dy;
				r_q <= r_q - Aw'(1);
			end else begin
				x_q <= ex;
				y_q <= ey;
				r_q <= r_q + Aw'(1);
			end
		end
	end

	// final xor for decrypt and PKCS7 check
	always_comb begin
		bad = 1'b0;
		fx = dec_q ? (x_q ^ chx_q) : x_q;
		fy = dec_q ? (y_q ^ chy_q) : y_q;
		pb = fy[63:56];
		if (pb == 8'd0 || pb > 8'd16) bad = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (8'(16 - i) <= pb) begin
				if (i < 8) begin
					if (fx[8*i +: 8] != pb) bad = 1'b1;
				end else if (fy[8*(i-8) +: 8] != pb) bad = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_x <= fx;
			res_y <= fy;
			res_err <= dec_q && last_q && bad;
			res_last <= last_q && (dec_q || nb_q != 5'd16 || cmd.pad_last);
			if (dec_q && last_q)
				res_bytes <= bad ? 5'd0 : 5'(5'd16 - pb[4:0]);
			else
				res_bytes <= 5'd16;
		end
	end
endmodule
`default_nettype wire

[design/spk_ctrl.sv]
// Speck128 CBC controller: key schedule and block sequencing, output handshake.
// Depends on spk_pkg and the macros header.
`default_nettype none
`include "speck128_cbc_engine_unit_macros.svh"
module spk_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              key_wr,
	input  wire logic              in_tvalid,
	output logic                   in_tready,
	output logic                   out_tvalid,
	input  wire logic              out_tready,
	output spk_pkg::spk_cmd_t      cmd,
	input  wire spk_pkg::spk_sts_t sts
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_KS, ST_RUN, ST_FIN, ST_OUT, ST_PAD, ST_PRUN, ST_PFIN
	} state_t;
	state_t state_q;
	logic pad_q;

	assign in_tready = (state_q == ST_IDLE) && !key_wr;

	always_comb begin
		cmd = '0;
		cmd.ks_start = key_wr;
		cmd.ks_step  = (state_q == ST_KS) && !sts.ks_done && !key_wr;
		cmd.load_in  = in_tvalid && in_tready;
		cmd.load_pad = (state_q == ST_PAD);
		cmd.rnd_step = (state_q == ST_RUN || state_q == ST_PRUN) && !sts.rnd_done;
		// result registers are only written once the previous result has gone
		cmd.finish   = (state_q == ST_FIN || state_q == ST_PFIN) &&
			(!out_tvalid || out_tready);
		cmd.pad_last = (state_q == ST_PFIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_tvalid <= 1'b0;
			pad_q <= 1'b0;
		end else begin
			out_tvalid <= cmd.finish || (out_tvalid && !out_tready);
			if (key_wr) state_q <= ST_KS;
			else case (state_q)
				ST_IDLE: if (cmd.load_in) state_q <= ST_RUN;
				ST_KS:   if (sts.ks_done) state_q <= ST_IDLE;
				ST_RUN:  if (sts.rnd_done) state_q <= ST_FIN;
				ST_FIN: begin
					if (cmd.finish) begin
						pad_q <= sts.need_pad;
						state_q <= sts.need_pad ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD:  state_q <= ST_PRUN;
				ST_PRUN: if (sts.rnd_done) state_q <= ST_PFIN;
				ST_PFIN: begin
					if (cmd.finish) begin
						pad_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SPK_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_tready)
	`SPK_ASSERT_NXT(a_run_after_accept, clk, arst_n, cmd.load_in && !key_wr, state_q == ST_RUN)
	`SPK_ASSERT_IMP(a_pad_flag, clk, arst_n, state_q == ST_PRUN, pad_q)
endmodule
`default_nettype wire

[sim/speck128_cbc_checker.sv]
// Scoreboard for the speck128 CBC engine: mirrors the registers, predicts each result.
// Depends on spk_pkg.
`timescale 1ns / 1ps
module speck128_cbc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [135:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output int           fails,
	output int           pending
);
	typedef struct packed {
		logic [63:0] x;
		logic [63:0] y;
		logic [4:0]  nbytes;
		logic        last;
		logic        err;
	} cbc_block_t;

	logic [63:0] kw [0:3];
	logic [1:0]  ksize;
	logic        decrypt;
	logic [63:0] ivx, ivy;
	logic [63:0] rk [0:33];
	logic [63:0] chx, chy;
	cbc_block_t  block_q [$];

	assign pending = block_q.size();

	function automatic logic [63:0] ror(logic [63:0] v, int r);
		return (v >> r) | (v << (64 - r));
	endfunction

	function automatic logic [63:0] rol(logic [63:0] v, int r);
		return (v << r) | (v >> (64 - r));
	endfunction

	function automatic int rounds();
		return 32 + ((ksize >= 2) ? 2 : ksize);
	endfunction

	function automatic void expand();
		logic [63:0] lw [0:2];
		logic [63:0] nl;
		int n, j;
		n = ((ksize >= 2) ? 2 : ksize) + 1;
		j = 0;
		lw[0] = kw[1];
		lw[1] = kw[2];
		lw[2] = kw[3];
		rk[0] = kw[0];
		for (int i = 0; i + 1 < rounds(); i++) begin
			nl = (rk[i] + ror(lw[j], 8)) ^ 64'(i);
			rk[i + 1] = rol(rk[i], 3) ^ nl;
			lw[j] = nl;
			j = (j + 1 >= n) ? 0 : j + 1;
		end
	endfunction

	// CBC encrypt in place, chain follows the ciphertext
	function automatic void cbc_enc(inout logic [63:0] x, inout logic [63:0] y);
		x ^= chx;
		y ^= chy;
		for (int i = 0; i < rounds(); i++) begin
			x = (ror(x, 8) + y) ^ rk[i];
			y = rol(y, 3) ^ x;
		end
		chx = x;
		chy = y;
	endfunction

	function automatic logic [7:0] byte_at(logic [63:0] x, logic [63:0] y, int i);
		return (i < 8) ? x[8*i +: 8] : y[8*(i-8) +: 8];
	endfunction

	function automatic void predict_block(logic [135:0] d);
		logic [63:0] x, y, cx, cy;
		int nb, p;
		logic first, last, bad;
		x = d[63:0];
		y = d[127:64];
		nb = d[132:128];
		first = d[133];
		last = d[134];
		if (first) begin
			chx = ivx;
			chy = ivy;
		end
		if (nb > 16 || !last) nb = 16;
		if (!decrypt) begin
			if (last && nb < 16) begin
				for (int i = nb; i < 16; i++)
					if (i < 8) x[8*i +: 8] = 8'(16 - nb);
					else y[8*(i-8) +: 8] = 8'(16 - nb);
				cbc_enc(x, y);
				block_q.push_back('{x, y, 5'd16, 1'b1, 1'b0});
			end else begin
				cbc_enc(x, y);
				block_q.push_back('{x, y, 5'd16, 1'b0, 1'b0});
				if (last) begin
					x = spk_pkg::PadWord;
					y = spk_pkg::PadWord;
					cbc_enc(x, y);
					block_q.push_back('{x, y, 5'd16, 1'b1, 1'b0});
				end
			end
		end else begin
			cx = x;
			cy = y;
			for (int i = rounds() - 1; i >= 0; i--) begin
				y = ror(y ^ x, 3);
				x = rol((x ^ rk[i]) - y, 8);
			end
			x ^= chx;
			y ^= chy;
			chx = cx;
			chy = cy;
			if (!last) begin
				block_q.push_back('{x, y, 5'd16, 1'b0, 1'b0});
			end else begin
				p = byte_at(x, y, 15);
				bad = (p == 0 || p > 16);
				if (!bad)
					for (int i = 16 - p; i < 16; i++)
						if (byte_at(x, y, i) != p) bad = 1'b1;
				if (bad) block_q.push_back('{x, y, 5'd0, 1'b1, 1'b1});
				else block_q.push_back('{x, y, 5'(16 - p), 1'b1, 1'b0});
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cbc_block_t e;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) kw[i] = '0;
			ksize = '0;
			decrypt = 1'b0;
			ivx = '0;
			ivy = '0;
			chx = '0;
			chy = '0;
			for (int i = 0; i < 34; i++) rk[i] = '0;
			block_q.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spk_pkg::RegKey0, spk_pkg::RegKey1, spk_pkg::RegKey2,
					spk_pkg::RegKey3: begin
						kw[cfg_index] = cfg_data;
						expand();
					end
					spk_pkg::RegKsize: begin
						ksize = cfg_data[1:0];
						expand();
					end
					spk_pkg::RegMode: decrypt = cfg_data[0];
					spk_pkg::RegIvX:  ivx = cfg_data;
					spk_pkg::RegIvY:  ivy = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) predict_block(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (block_q.size() == 0) begin
					$error("unexpected result block %h", m_axis_tdata);
					fails++;
				end else begin
					e = block_q.pop_front();
					if (m_axis_tdata[63:0] !== e.x) begin
						$error("out_word_x exp %h got %h", e.x, m_axis_tdata[63:0]);
						fails++;
					end
					if (m_axis_tdata[127:64] !== e.y) begin
						$error("out_word_y exp %h got %h", e.y, m_axis_tdata[127:64]);
						fails++;
					end
					if (m_axis_tdata[132:128] !== e.nbytes) begin
						$error("out_bytes exp %0d got %0d", e.nbytes, m_axis_tdata[132:128]);
						fails++;
					end
					if (m_axis_tdata[133] !== e.last) begin
						$error("out_last exp %b got %b", e.last, m_axis_tdata[133]);
						fails++;
					end
					if (m_axis_tdata[134] !== e.err) begin
						$error("pad_error exp %b got %b", e.err, m_axis_tdata[134]);
						fails++;
					end
				end
			end
		end
	end
endmodule

[sim/testbench.sv]
// Top of the speck128 CBC engine bench: clock, reset, stimulus and verdict.
// Depends on spk_pkg, speck128_cbc_engine_unit and speck128_cbc_checker.
`timescale 1ns / 1ps
module testbench;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;
	int           fails;
	int           pending;

	// idling percentages for the current phase
	int           send_idle = 0;
	int           recv_stall = 0;
	int           hold_cycles = 0;   // long receiver hold-off, counted below
	int           cycle_count = 0;

	// ciphertext captured during encrypt phases, replayed for decrypt
	logic         capture_on = 1'b0;
	logic [135:0] cipher_q [$];
	logic         msg_first_q [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	speck128_cbc_engine_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	speck128_cbc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	// receiver: random stalls, plus an occasional long hold-off so that
	// the engine backs up and drops s_axis_tready
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (capture_on && m_axis_tvalid && m_axis_tready) cipher_q.push_back(m_axis_tdata);
	end

	// watchdog, sized for the slowest legal run many times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("speck128_cbc_engine_unit verification failed");
			$finish;
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// one request: x, y, in_bytes, first, last; returns after the handshake
	task automatic send_block(logic [63:0] x, logic [63:0] y, logic [4:0] nb,
			logic first, logic last);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, last, first, nb, y, x};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drain: wait until nothing is outstanding, pad results included
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// random message of 1..4 blocks; first flag mostly set
	task automatic encrypt_messages(int count);
		int len;
		logic first;
		for (int m = 0; m < count; m++) begin
			len = $urandom_range(1, 4);
			first = ($urandom_range(9) != 0);
			msg_first_q.push_back(first);
			for (int b = 0; b < len; b++)
				send_block(rnd64(), rnd64(), 5'($urandom_range(31)),
					(b == 0) ? first : 1'b0, b == len - 1);
		end
	endtask

	// replay captured ciphertext, sometimes with a flipped bit so the
	// padding check can fail
	task automatic decrypt_replay();
		logic [135:0] c;
		logic first, start;
		int flip;
		start = 1'b1;
		first = 1'b0;
		while (cipher_q.size() != 0) begin
			c = cipher_q.pop_front();
			if (start) first = msg_first_q.pop_front();
			if ($urandom_range(11) == 0) begin
				flip = $urandom_range(127);
				c[flip] = ~c[flip];
			end
			send_block(c[63:0], c[127:64], 5'($urandom_range(31)), start && first, c[133]);
			start = c[133];
		end
	endtask

	task automatic set_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
			logic [63:0] k2, logic [63:0] k3, logic [63:0] vx, logic [63:0] vy);
		cfg_write(spk_pkg::RegKsize, 64'(ks));
		cfg_write(spk_pkg::RegKey0, k0);
		cfg_write(spk_pkg::RegKey1, k1);
		cfg_write(spk_pkg::RegKey2, k2);
		cfg_write(spk_pkg::RegKey3, k3);
		cfg_write(spk_pkg::RegIvX, vx);
		cfg_write(spk_pkg::RegIvY, vy);
		cfg_write(spk_pkg::RegMode, 64'd0);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] ones;
		ones = '1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edge values, short last blocks, chaining without first
		set_key(2'd0, '0, '0, '0, '0, '0, '0);
		capture_on <= 1'b1;
		@(posedge clk);
		send_block('0, '0, 5'd0, 1'b1, 1'b1);
		send_block(ones, ones, 5'd15, 1'b1, 1'b1);
		send_block(ones, '0, 5'd16, 1'b1, 1'b1);
		send_block('0, ones, 5'd31, 1'b1, 1'b1);
		send_block(ones, ones, 5'd1, 1'b1, 1'b0);
		send_block(64'h0123456789abcdef, ones, 5'd0, 1'b0, 1'b0);
		send_block(ones, '0, 5'd8, 1'b0, 1'b1);
		send_block(rnd64(), rnd64(), 5'd17, 1'b0, 1'b1);
		settle();
		capture_on <= 1'b0;
		cfg_write(spk_pkg::RegMode, 64'd1);
		cfg_we <= 1'b0;
		@(posedge clk);
		// decrypt the captured blocks unchanged: good padding of every length seen
		for (int i = 0; i < cipher_q.size(); i++)
			send_block(cipher_q[i][63:0], cipher_q[i][127:64], 5'd0,
				i == 0 || (cipher_q[i-1][133] && i != 9), cipher_q[i][133]);
		send_block('0, '0, 5'd16, 1'b1, 1'b1);
		send_block(ones, ones, 5'd0, 1'b0, 1'b1);
		settle();
		cipher_q.delete();

		for (int s = 0; s < 8; s++) begin
			case (s % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 72; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 72; end
				default: begin send_idle = 8; recv_stall = 8; end
			endcase
			if (s == 1) set_key(2'd1, ones, ones, ones, ones, ones, ones);
			else if (s == 2) set_key(2'd2, rnd64(), rnd64(), rnd64(), rnd64(), '0, '0);
			else if (s == 3) set_key(2'd3, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
			else set_key(2'(s % 3), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
			msg_first_q.delete();
			cipher_q.delete();
			msg_first_q.push_back(1'b1);
			capture_on <= 1'b1;
			// first block always restarts the chain so the replay matches
			send_block(rnd64(), rnd64(), 5'($urandom_range(31)), 1'b1, 1'b1);
			if (s == 4) hold_cycles <= 400;
			encrypt_messages(29);
			settle();
			capture_on <= 1'b0;
			cfg_write(spk_pkg::RegMode, 64'd1);
			cfg_we <= 1'b0;
			@(posedge clk);
			decrypt_replay();
			// a little noise: random ciphertext
			for (int n = 0; n < 4; n++)
				send_block(rnd64(), rnd64(), 5'($urandom_range(31)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			settle();
		end

		if (fails == 0) begin
			$display("speck128_cbc_engine_unit verification clean");
		end else begin
			$display("speck128_cbc_engine_unit verification failed");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+design
design/spk_pkg.sv
design/spk_datapath.sv
design/spk_ctrl.sv
design/speck128_cbc_engine_unit.sv
sim/speck128_cbc_checker.sv
sim/testbench.sv
